### hdl/kcpa_pkg.sv
// ----------------------------------------------------------------------------
// kcpa_pkg
// Shared types, codes and constants of the keypad code lock and proximity
// alarm.
// ----------------------------------------------------------------------------
package kcpa_pkg;

  localparam int CODE_KEYS = 4;
  localparam int KEY_W     = 4;
  localparam int CODE_W    = CODE_KEYS * KEY_W;
  localparam int LEN_W     = (CODE_KEYS > 1) ? $clog2(CODE_KEYS) : 1;
  localparam int PREV_W    = KEY_W + 1;

  localparam int OP_W      = 3;
  localparam int EVENT_W   = 3;
  localparam int ECHO_W    = 20;
  localparam int DIST_W    = 10;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int HOLD_W    = 17;
  localparam int PAUSE_W   = 16;
  localparam int TALLY_W   = 4;

  localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
  localparam logic [OP_W-1:0] OP_KEY    = 3'd1;
  localparam logic [OP_W-1:0] OP_ECHO   = 3'd2;
  localparam logic [OP_W-1:0] OP_ARM    = 3'd3;
  localparam logic [OP_W-1:0] OP_DISARM = 3'd4;

  localparam logic [EVENT_W-1:0] EV_NONE     = 3'd0;
  localparam logic [EVENT_W-1:0] EV_ARMED    = 3'd1;
  localparam logic [EVENT_W-1:0] EV_DISARMED = 3'd2;
  localparam logic [EVENT_W-1:0] EV_WRONG    = 3'd3;
  localparam logic [EVENT_W-1:0] EV_ALERT    = 3'd4;
  localparam logic [EVENT_W-1:0] EV_CLEARED  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_SECRET  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAR     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DISABLE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ALERT   = 3'd5;

  localparam logic [KEY_W-1:0]   KEY_CLEAR = 4'd15;
  localparam logic [PREV_W-1:0]  KEY_NONE  = 5'd16;
  localparam logic [TALLY_W-1:0] TALLY_MAX = 4'd15;

  localparam int ECHO_SCALE  = 17;
  localparam int US_PER_UNIT = 1000;
  localparam int PROD_W      = 25;

  localparam logic [CFG_W-1:0]   SECRET_RST  = 16'h0512;
  localparam logic [DIST_W-1:0]  NEAR_RST    = 10'd10;
  localparam logic [DIST_W-1:0]  FAR_RST     = 10'd30;
  localparam logic [CFG_W-1:0]   HOLDOFF_RST = 16'd250;
  localparam logic [CFG_W-1:0]   DISABLE_RST = 16'd60000;
  localparam logic [TALLY_W-1:0] ALERT_RST   = 4'd3;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [KEY_W-1:0]  key_index;
    logic [ECHO_W-1:0] echo_us;
  } req_t;

  typedef struct packed {
    logic               alarm_on;
    logic [EVENT_W-1:0] event_res;
    logic [1:0]         entered_count;
    logic [TALLY_W-1:0] wrong_count;
    logic               sensing_paused;
  } rsp_t;

  typedef struct packed {
    logic [CFG_W-1:0]   secret_code;
    logic [DIST_W-1:0]  near_cm;
    logic [DIST_W-1:0]  far_cm;
    logic [CFG_W-1:0]   holdoff_ms;
    logic [CFG_W-1:0]   disable_ms;
    logic [TALLY_W-1:0] alert_after;
  } cfg_t;

endpackage

### hdl/keypad_code_proximity_alarm.sv
// ----------------------------------------------------------------------------
// keypad_code_proximity_alarm
// Keypad code lock with ultrasonic proximity alarm: top level with
// configuration registers, request register and result register.
// ----------------------------------------------------------------------------
// One result per request. A request is held in the request register and is
// evaluated in a single combinational pass into the result register, and a
// new request is taken every cycle while the result side keeps up. Echo range
// uses constant multiplies and compares.
module keypad_code_proximity_alarm (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [kcpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kcpa_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  kcpa_pkg::req_t                 in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output kcpa_pkg::rsp_t                 out_data
);

  kcpa_pkg::cfg_t cfg;
  logic           req_valid;
  kcpa_pkg::req_t req;
  logic           advance;
  logic           in_window;
  kcpa_pkg::rsp_t result;

  assign advance  = req_valid && (!out_valid || !out_stall);
  assign in_stall = req_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.secret_code <= kcpa_pkg::SECRET_RST;
      cfg.near_cm     <= kcpa_pkg::NEAR_RST;
      cfg.far_cm      <= kcpa_pkg::FAR_RST;
      cfg.holdoff_ms  <= kcpa_pkg::HOLDOFF_RST;
      cfg.disable_ms  <= kcpa_pkg::DISABLE_RST;
      cfg.alert_after <= kcpa_pkg::ALERT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        kcpa_pkg::REG_SECRET:  cfg.secret_code <= cfg_data;
        kcpa_pkg::REG_NEAR:    cfg.near_cm     <= cfg_data[kcpa_pkg::DIST_W-1:0];
        kcpa_pkg::REG_FAR:     cfg.far_cm      <= cfg_data[kcpa_pkg::DIST_W-1:0];
        kcpa_pkg::REG_HOLDOFF: cfg.holdoff_ms  <= cfg_data;
        kcpa_pkg::REG_DISABLE: cfg.disable_ms  <= cfg_data;
        kcpa_pkg::REG_ALERT:   cfg.alert_after <= cfg_data[kcpa_pkg::TALLY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      req_valid <= 1'b1;
    end else if (advance) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) req <= in_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_data <= result;
  end

  kcpa_window u_window (
    .echo_us   (req.echo_us),
    .near_cm   (cfg.near_cm),
    .far_cm    (cfg.far_cm),
    .in_window (in_window)
  );

  kcpa_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (advance),
    .req       (req),
    .cfg       (cfg),
    .in_window (in_window),
    .result    (result)
  );

endmodule

### hdl/kcpa_window.sv
// ----------------------------------------------------------------------------
// kcpa_window
// Echo range check: flags a distance strictly between near_cm and far_cm,
// comparing the scaled echo against scaled limits instead of dividing.
// ----------------------------------------------------------------------------
module kcpa_window (
  input  logic [kcpa_pkg::ECHO_W-1:0] echo_us,
  input  logic [kcpa_pkg::DIST_W-1:0] near_cm,
  input  logic [kcpa_pkg::DIST_W-1:0] far_cm,
  output logic                        in_window
);

  logic [kcpa_pkg::PROD_W-1:0] scaled;
  logic [kcpa_pkg::PROD_W-1:0] near_lim;
  logic [kcpa_pkg::PROD_W-1:0] far_lim;

  always_comb begin
    scaled   = kcpa_pkg::PROD_W'(echo_us) * kcpa_pkg::PROD_W'(kcpa_pkg::ECHO_SCALE);
    near_lim = (kcpa_pkg::PROD_W'(near_cm) + kcpa_pkg::PROD_W'(1))
               * kcpa_pkg::PROD_W'(kcpa_pkg::US_PER_UNIT);
    far_lim  = kcpa_pkg::PROD_W'(far_cm) * kcpa_pkg::PROD_W'(kcpa_pkg::US_PER_UNIT);
    in_window = (scaled >= near_lim) && (scaled < far_lim);
  end

endmodule

### hdl/kcpa_core.sv
// ----------------------------------------------------------------------------
// kcpa_core
// Alarm state and its single-pass update: timers, code entry, wrong-code
// tally and arm/disarm, with the result of the request being applied.
// ----------------------------------------------------------------------------
module kcpa_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  kcpa_pkg::req_t req,
  input  kcpa_pkg::cfg_t cfg,
  input  logic           in_window,
  output kcpa_pkg::rsp_t result
);

  logic                          alarm_flag, alarm_flag_next;
  logic [kcpa_pkg::CODE_W-1:0]   entry_keys, entry_keys_next;
  logic [kcpa_pkg::LEN_W-1:0]    entry_length, entry_length_next;
  logic [kcpa_pkg::PREV_W-1:0]   previous_key, previous_key_next;
  logic [kcpa_pkg::HOLD_W-1:0]   holdoff_left, holdoff_left_next;
  logic [kcpa_pkg::PAUSE_W-1:0]  pause_left, pause_left_next;
  logic [kcpa_pkg::TALLY_W-1:0]  wrong_tally, wrong_tally_next;
  logic [kcpa_pkg::EVENT_W-1:0]  ev;

  logic                          paused;
  logic [kcpa_pkg::CODE_W-1:0]   word;
  logic                          complete;
  logic                          code_ok;
  logic [kcpa_pkg::TALLY_W-1:0]  tally_inc;

  always_comb begin
    paused    = (pause_left != '0);
    word      = (entry_keys << kcpa_pkg::KEY_W) | kcpa_pkg::CODE_W'(req.key_index);
    complete  = (entry_length == kcpa_pkg::LEN_W'(kcpa_pkg::CODE_KEYS - 1));
    code_ok   = (word == kcpa_pkg::CODE_W'(cfg.secret_code));
    tally_inc = (wrong_tally == kcpa_pkg::TALLY_MAX) ? wrong_tally
                                                     : wrong_tally + 1'b1;

    alarm_flag_next   = alarm_flag;
    entry_keys_next   = entry_keys;
    entry_length_next = entry_length;
    previous_key_next = previous_key;
    holdoff_left_next = holdoff_left;
    pause_left_next   = pause_left;
    wrong_tally_next  = wrong_tally;
    ev                = kcpa_pkg::EV_NONE;

    case (req.operation)
      kcpa_pkg::OP_TICK: begin
        if (holdoff_left != '0) holdoff_left_next = holdoff_left - 1'b1;
        if (paused) pause_left_next = pause_left - 1'b1;
      end
      kcpa_pkg::OP_KEY: begin
        if (!paused && holdoff_left == '0) begin
          if (req.key_index == kcpa_pkg::KEY_CLEAR) begin
            entry_keys_next   = '0;
            entry_length_next = '0;
            ev                = kcpa_pkg::EV_CLEARED;
          end else if ({1'b0, req.key_index} != previous_key) begin
            previous_key_next = {1'b0, req.key_index};
            holdoff_left_next = kcpa_pkg::HOLD_W'(cfg.holdoff_ms) + 1'b1;
            if (!complete) begin
              entry_keys_next   = word;
              entry_length_next = entry_length + 1'b1;
            end else begin
              entry_keys_next   = '0;
              entry_length_next = '0;
              if (code_ok) begin
                wrong_tally_next = '0;
                if (alarm_flag) begin
                  alarm_flag_next = 1'b0;
                  pause_left_next = cfg.disable_ms;
                  ev              = kcpa_pkg::EV_DISARMED;
                end
              end else begin
                wrong_tally_next = tally_inc;
                ev = (tally_inc >= cfg.alert_after) ? kcpa_pkg::EV_ALERT
                                                    : kcpa_pkg::EV_WRONG;
              end
            end
          end
        end
      end
      kcpa_pkg::OP_ECHO: begin
        if (!paused && in_window && !alarm_flag) begin
          alarm_flag_next = 1'b1;
          ev              = kcpa_pkg::EV_ARMED;
        end
      end
      kcpa_pkg::OP_ARM: begin
        if (!alarm_flag) begin
          alarm_flag_next = 1'b1;
          ev              = kcpa_pkg::EV_ARMED;
        end
      end
      kcpa_pkg::OP_DISARM: begin
        if (alarm_flag) begin
          alarm_flag_next = 1'b0;
          pause_left_next = cfg.disable_ms;
          ev              = kcpa_pkg::EV_DISARMED;
        end
      end
      default: begin
      end
    endcase

    result.alarm_on       = alarm_flag_next;
    result.event_res      = ev;
    result.entered_count  = 2'(entry_length_next);
    result.wrong_count    = wrong_tally_next;
    result.sensing_paused = (pause_left_next != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_flag   <= 1'b0;
      entry_keys   <= '0;
      entry_length <= '0;
      previous_key <= kcpa_pkg::KEY_NONE;
      holdoff_left <= '0;
      pause_left   <= '0;
      wrong_tally  <= '0;
    end else if (fire) begin
      alarm_flag   <= alarm_flag_next;
      entry_keys   <= entry_keys_next;
      entry_length <= entry_length_next;
      previous_key <= previous_key_next;
      holdoff_left <= holdoff_left_next;
      pause_left   <= pause_left_next;
      wrong_tally  <= wrong_tally_next;
    end
  end

  a_disarm_clears: assert property (@(posedge clk) disable iff (rst)
    fire && result.event_res == kcpa_pkg::EV_DISARMED |=> !alarm_flag)
    else $error("alarm still set after disarm");

  a_arm_sets: assert property (@(posedge clk) disable iff (rst)
    fire && result.event_res == kcpa_pkg::EV_ARMED |=> alarm_flag)
    else $error("alarm not set after arm");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(holdoff_left) && $stable(pause_left) && $stable(wrong_tally))
    else $error("state moved without a request");

  a_wrong_counts: assert property (@(posedge clk) disable iff (rst)
    fire && (result.event_res == kcpa_pkg::EV_WRONG ||
             result.event_res == kcpa_pkg::EV_ALERT) |=> wrong_tally != '0)
    else $error("wrong code left tally at zero");

endmodule

### sim/alarm_status_checker.sv
// ----------------------------------------------------------------------------
// alarm_status_checker
// Watches the request, result and register ports of the keypad code lock and
// proximity alarm, predicts the status word for every accepted request from
// its own copy of the lock state and registers, and compares each accepted
// result field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module alarm_status_checker
  import kcpa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  req_t                 in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  rsp_t                 out_data,
  output int                   mismatches,
  output int                   pending
);

  cfg_t              regs;
  logic              armed;
  logic [CODE_W-1:0] entry_word;
  int unsigned       entry_len;
  logic [PREV_W-1:0] last_key;
  logic [HOLD_W-1:0] holdoff_left;
  logic [PAUSE_W-1:0] pause_left;
  logic [TALLY_W-1:0] wrong_tally;

  rsp_t expected_status[$];

  function automatic void reset_lock();
    regs.secret_code = SECRET_RST;
    regs.near_cm     = NEAR_RST;
    regs.far_cm      = FAR_RST;
    regs.holdoff_ms  = HOLDOFF_RST;
    regs.disable_ms  = DISABLE_RST;
    regs.alert_after = ALERT_RST;
    armed        = 1'b0;
    entry_word   = '0;
    entry_len    = 0;
    last_key     = KEY_NONE;
    holdoff_left = '0;
    pause_left   = '0;
    wrong_tally  = '0;
  endfunction

  function automatic void load_reg(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_W-1:0] data);
    case (idx)
      REG_SECRET:  regs.secret_code = data;
      REG_NEAR:    regs.near_cm     = data[DIST_W-1:0];
      REG_FAR:     regs.far_cm      = data[DIST_W-1:0];
      REG_HOLDOFF: regs.holdoff_ms  = data;
      REG_DISABLE: regs.disable_ms  = data;
      REG_ALERT:   regs.alert_after = data[TALLY_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [EVENT_W-1:0] raise_alarm();
    if (armed) return EV_NONE;
    armed = 1'b1;
    return EV_ARMED;
  endfunction

  function automatic logic [EVENT_W-1:0] drop_alarm();
    if (!armed) return EV_NONE;
    armed      = 1'b0;
    pause_left = regs.disable_ms;
    return EV_DISARMED;
  endfunction

  function automatic logic [EVENT_W-1:0] press_key(input logic [KEY_W-1:0] key);
    logic [CODE_W-1:0]  word;
    logic [EVENT_W-1:0] ev;
    if (pause_left != 0 || holdoff_left != 0) return EV_NONE;
    if (key == KEY_CLEAR) begin
      entry_word = '0;
      entry_len  = 0;
      return EV_CLEARED;
    end
    if ({1'b0, key} == last_key) return EV_NONE;
    last_key     = {1'b0, key};
    holdoff_left = {1'b0, regs.holdoff_ms} + 1'b1;
    word = {entry_word[CODE_W-KEY_W-1:0], key};
    if (entry_len + 1 < CODE_KEYS) begin
      entry_word = word;
      entry_len++;
      return EV_NONE;
    end
    entry_word = '0;
    entry_len  = 0;
    if (word == regs.secret_code[CODE_W-1:0]) begin
      ev = drop_alarm();
      wrong_tally = '0;
      return ev;
    end
    if (wrong_tally != TALLY_MAX) wrong_tally++;
    return (wrong_tally >= regs.alert_after) ? EV_ALERT : EV_WRONG;
  endfunction

  function automatic logic [EVENT_W-1:0] sense_echo(input logic [ECHO_W-1:0] echo);
    longint unsigned distance_cm;
    if (pause_left != 0) return EV_NONE;
    distance_cm = (longint'(echo) * ECHO_SCALE) / US_PER_UNIT;
    if (distance_cm > regs.near_cm && distance_cm < regs.far_cm) return raise_alarm();
    return EV_NONE;
  endfunction

  function automatic rsp_t step_lock(input req_t r);
    rsp_t               s;
    logic [EVENT_W-1:0] ev;
    ev = EV_NONE;
    case (r.operation)
      OP_TICK: begin
        if (holdoff_left != 0) holdoff_left--;
        if (pause_left != 0) pause_left--;
      end
      OP_KEY:    ev = press_key(r.key_index);
      OP_ECHO:   ev = sense_echo(r.echo_us);
      OP_ARM:    ev = raise_alarm();
      OP_DISARM: ev = drop_alarm();
      default: ;
    endcase
    s.alarm_on       = armed;
    s.event_res      = ev;
    s.entered_count  = 2'(entry_len);
    s.wrong_count    = wrong_tally;
    s.sensing_paused = (pause_left != 0);
    return s;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      reset_lock();
      expected_status.delete();
      mismatches = 0;
    end else begin
      if (cfg_write) load_reg(cfg_index, cfg_data);
      if (out_valid && !out_stall) begin
        if (expected_status.size() == 0) begin
          mismatches++;
          $display("%0t: result with no request waiting, expected none, got %h",
                   $time, out_data);
        end else begin
          want = expected_status.pop_front();
          check_field("alarm_on", want.alarm_on, out_data.alarm_on);
          check_field("event_res", want.event_res, out_data.event_res);
          check_field("entered_count", want.entered_count, out_data.entered_count);
          check_field("wrong_count", want.wrong_count, out_data.wrong_count);
          check_field("sensing_paused", want.sensing_paused, out_data.sensing_paused);
        end
      end
      if (in_valid && !in_stall) expected_status.push_back(step_lock(in_data));
    end
    pending = expected_status.size();
  end

endmodule

### sim/keypad_code_proximity_alarm_tb.sv
// ----------------------------------------------------------------------------
// keypad_code_proximity_alarm_tb
// Drives ticks, key presses, echo widths and remote commands into the alarm
// controller under several register settings and idle patterns; short
// directed sequences are followed by random code attempts and noise, and the
// status checker beside the block tallies every mismatch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module keypad_code_proximity_alarm_tb;
  import kcpa_pkg::*;

  localparam int RX_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES   = 6;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SECRET;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  req_t                 in_data   = '0;
  logic                 out_stall = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  rsp_t                 out_data;

  int          mismatches;
  int          pending;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  bit          rx_hold_req = 1'b0;
  int unsigned req_total   = 0;
  int unsigned settings    = 1;
  cfg_t        active_cfg;
  logic [KEY_W-1:0] code_keys[CODE_KEYS];

  keypad_code_proximity_alarm dut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
  );

  alarm_status_checker status_check (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .mismatches, .pending
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        out_stall <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic req_t rand_req(input logic [OP_W-1:0] op);
    req_t r;
    r.operation = op;
    r.key_index = KEY_W'($urandom);
    r.echo_us   = ECHO_W'($urandom);
    return r;
  endfunction

  function automatic logic [CFG_W-1:0] rand_secret();
    logic [KEY_W-1:0] digit;
    logic [KEY_W-1:0] prior;
    logic [CFG_W-1:0] word;
    word  = '0;
    prior = KEY_CLEAR;
    for (int i = 0; i < CODE_KEYS; i++) begin
      do digit = KEY_W'($urandom_range(0, 14)); while (digit == prior);
      word  = {word[CFG_W-KEY_W-1:0], digit};
      prior = digit;
    end
    return word;
  endfunction

  task automatic push_req(input req_t r);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    req_total++;
  endtask

  task automatic send_key(input logic [KEY_W-1:0] key);
    req_t r;
    r = rand_req(OP_KEY);
    r.key_index = key;
    push_req(r);
  endtask

  task automatic send_echo(input logic [ECHO_W-1:0] echo);
    req_t r;
    r = rand_req(OP_ECHO);
    r.echo_us = echo;
    push_req(r);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) push_req(rand_req(OP_TICK));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input cfg_t c);
    active_cfg = c;
    for (int i = 0; i < CODE_KEYS; i++)
      code_keys[i] = c.secret_code[(CODE_KEYS-1-i)*KEY_W +: KEY_W];
    cfg_write <= 1'b1;
    cfg_index <= REG_SECRET;
    cfg_data  <= c.secret_code;
    @(posedge clk);
    cfg_index <= REG_NEAR;
    cfg_data  <= CFG_W'(c.near_cm);
    @(posedge clk);
    cfg_index <= REG_FAR;
    cfg_data  <= CFG_W'(c.far_cm);
    @(posedge clk);
    cfg_index <= REG_HOLDOFF;
    cfg_data  <= c.holdoff_ms;
    @(posedge clk);
    cfg_index <= REG_DISABLE;
    cfg_data  <= c.disable_ms;
    @(posedge clk);
    cfg_index <= REG_ALERT;
    cfg_data  <= CFG_W'(c.alert_after);
    @(posedge clk);
    cfg_write <= 1'b0;
    settings++;
  endtask

  task automatic code_attempt(input bit correct);
    logic [KEY_W-1:0] keys[CODE_KEYS];
    logic [KEY_W-1:0] lead;
    int gap;
    int slot;
    gap  = (active_cfg.holdoff_ms < 8) ? int'(active_cfg.holdoff_ms) + 1 : 8;
    keys = code_keys;
    if (!correct) begin
      slot = $urandom_range(0, CODE_KEYS - 1);
      keys[slot] = KEY_W'($urandom_range(0, 14));
    end
    if ($urandom_range(0, 1)) begin
      if ($urandom_range(0, 1)) send_echo(ECHO_W'($urandom_range(0,
                                  59 * (int'(active_cfg.far_cm) + 2))));
      else push_req(rand_req(OP_ARM));
    end
    if ($urandom_range(0, 1)) send_ticks($urandom_range(0, 10));
    do lead = KEY_W'($urandom_range(0, 14)); while (lead == keys[0]);
    send_ticks(gap);
    send_key(lead);
    send_ticks(gap);
    send_key(KEY_CLEAR);
    for (int i = 0; i < CODE_KEYS; i++) begin
      send_ticks(gap);
      send_key(keys[i]);
    end
  endtask

  task automatic random_unit();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) code_attempt($urandom_range(0, 99) < 60);
    else if (pick < 45) send_ticks($urandom_range(1, 3));
    else if (pick < 60) push_req(rand_req(OP_KEY));
    else if (pick < 75)
      send_echo(ECHO_W'($urandom_range(0, 59 * (int'(active_cfg.far_cm) + 2))));
    else if (pick < 82) push_req(rand_req(OP_ECHO));
    else if (pick < 89) push_req(rand_req(OP_ARM));
    else if (pick < 96) push_req(rand_req(OP_DISARM));
    else push_req(rand_req(OP_DISARM + OP_W'($urandom_range(1, 3))));
  endtask

  task automatic run_phase(input cfg_t c, input int tx, input int rx,
                           input int unsigned items, input bit squeeze);
    int unsigned first;
    bit held;
    write_cfg(c);
    tx_idle_pct = tx;
    rx_idle_pct = rx;
    first = req_total;
    held  = 1'b0;
    while (req_total - first < items) begin
      if (squeeze && !held && req_total - first >= items / 2) begin
        rx_hold_req = 1'b1;
        held = 1'b1;
      end
      random_unit();
    end
    wait_idle();
  endtask

  initial begin
    cfg_t setting;
    active_cfg = '{SECRET_RST, NEAR_RST, FAR_RST, HOLDOFF_RST, DISABLE_RST, ALERT_RST};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    tx_idle_pct = 22;
    rx_idle_pct = 50;

    // reset window: boundaries of the distance window, then arm
    push_req(rand_req(OP_DISARM));
    send_echo('1);
    send_echo(ECHO_W'(1765));
    send_echo(ECHO_W'(647));
    send_echo(ECHO_W'(648));
    push_req(rand_req(OP_ARM));
    wait_idle();

    setting = '{SECRET_RST, NEAR_RST, FAR_RST, 16'd0, 16'd2, 4'd1};
    write_cfg(setting);
    send_ticks(1);
    send_key(4'd5);
    send_ticks(1);
    send_key(4'd5);
    send_key(KEY_CLEAR);
    send_key(4'd1);
    send_ticks(1);
    send_key(4'd5);
    send_ticks(1);
    send_key(4'd2);
    send_ticks(1);
    send_key(4'd3);
    send_echo(ECHO_W'(648));
    send_ticks(2);
    send_key(4'd0);
    send_ticks(1);
    send_key(4'd14);
    send_ticks(1);
    send_key(4'd0);
    send_ticks(1);
    send_key(4'd14);
    wait_idle();

    setting = '{rand_secret(), NEAR_RST, FAR_RST, 16'd0, 16'd3, 4'd1};
    run_phase(setting, 22, 50, 450, 1'b1);

    setting.secret_code = rand_secret();
    setting.near_cm     = DIST_W'($urandom_range(0, 200));
    setting.far_cm      = setting.near_cm + DIST_W'($urandom_range(2, 100));
    setting.holdoff_ms  = 16'd2;
    setting.disable_ms  = 16'd8;
    setting.alert_after = 4'd4;
    run_phase(setting, 50, 22, 450, 1'b1);

    setting = '{16'h0000, 10'd1023, 10'd0, 16'd1, 16'd0, 4'd0};
    run_phase(setting, 0, 0, 300, 1'b1);

    setting = '{rand_secret(), 10'd0, 10'd1023, 16'd3, 16'd5, 4'd15};
    run_phase(setting, 0, 0, 400, 1'b0);

    setting = '{16'hFFFF, 10'd0, 10'd1023, 16'hFFFF, 16'hFFFF, 4'd15};
    run_phase(setting, 0, 0, 100, 1'b0);

    $display("Run covered %0d requests under %0d register settings, from reset values",
             req_total, settings);
    $display("to extreme windows, hold-offs and pauses, with idle gaps and receiver holds.");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/kcpa_pkg.sv
hdl/kcpa_window.sv
hdl/kcpa_core.sv
hdl/keypad_code_proximity_alarm.sv
sim/alarm_status_checker.sv
sim/keypad_code_proximity_alarm_tb.sv
